### src/date_time_string_validator_unit_assert.svh
// Assertion macros for the date/time validator checker
`ifndef DATE_TIME_STRING_VALIDATOR_UNIT_ASSERT_SVH
`define DATE_TIME_STRING_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during rst
`define DTSV_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dtsv checker: same-cycle implication violated");

// Next-cycle implication, sampled on clk, idle during rst
`define DTSV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dtsv checker: next-cycle implication violated");

// Next-cycle implication that is also checked across reset
`define DTSV_ASSERT_NEXT_ALWAYS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("dtsv checker: reset implication violated");

`endif

### src/dtsv_pkg.sv
// Shared types, codes and calendar helpers for the date/time validator
`default_nettype none

package dtsv_pkg;

  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 3;
  localparam int YEAR_W  = 9;
  localparam int MONTH_W = 4;

  // syntax_mode codes
  localparam logic [MODE_W-1:0] MODE_MONTH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WEEK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DATE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIME  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOCAL = 3'd4;

  // Separator characters
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // One character transaction
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } item_t;

  // Gregorian leap rule on the year modulo 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic cent;
    cent = (y == 9'd100) || (y == 9'd200) || (y == 9'd300);
    return (y == 9'd0) || ((y[1:0] == 2'd0) && !cent);
  endfunction

  // Weeks in the ISO year: 53 when Jan 1 falls on Thursday, or Wednesday in a leap year
  function automatic logic [6:0] max_week(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic [YEAR_W-1:0] hund;
    logic [6:0]        p100;
    logic [11:0]       total;
    logic [25:0]       prod;
    logic [11:0]       q7;
    logic [11:0]       rem7;
    logic [2:0]        dow;
    // previous year modulo 400
    p = (y == 9'd0) ? 9'd399 : y - 9'd1;
    if (p >= 9'd300) begin
      hund = 9'd300;
    end else if (p >= 9'd200) begin
      hund = 9'd200;
    end else if (p >= 9'd100) begin
      hund = 9'd100;
    end else begin
      hund = 9'd0;
    end
    p100  = 7'(p - hund);
    total = 12'd1 + 12'(5 * p[1:0]) + 12'({p100, 2'b00}) + 12'(6 * p);
    // divide by 7 with a reciprocal, exact below 2807
    prod  = 26'(total * 14'd2341);
    q7    = 12'(prod >> 14);
    rem7  = total - 12'(q7 * 3'd7);
    dow   = rem7[2:0];
    if ((dow == 3'd4) || ((dow == 3'd3) && is_leap(y))) begin
      return 7'd53;
    end
    return 7'd52;
  endfunction

  // Days in a month, zero for a month code out of range
  function automatic logic [4:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                       return leap ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### src/date_time_string_validator_unit.sv
// Top level of the streaming date/time string validator
//
//   channel   dir  width  contents
//   s_axis    in   8+1    tdata[7:0] char_code, tlast last_char
//   m_axis    out  8      tdata[0] string_valid, tdata[7:1] zero
//   cfg       in   3      syntax_mode write, no read-back
//
// One character per cycle, sustained while no final character waits; the parse state
// updates once per character. Results pass the input register, then the result register.
// Only the final character waits while the result register is full and stalled.
// rst is synchronous and clears the mode to month, the parse state and both valids.
`default_nettype none

module date_time_string_validator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dtsv_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_code
  input  wire logic                          s_axis_tlast,   // last_char
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [0] string_valid, [7:1] zero
  input  wire logic                          cfg_wr_en,
  input  wire logic [dtsv_pkg::MODE_W-1:0]   cfg_wr_data     // syntax_mode
);

  logic [dtsv_pkg::MODE_W-1:0] syntax_mode;
  logic                        in_valid;
  dtsv_pkg::item_t             in_item;
  logic                        out_valid;
  logic                        out_bit;
  logic                        out_free;
  logic                        in_fire;
  logic                        verdict;

  // Handshake between the input register and the result register
  assign out_free      = !out_valid || m_axis_tready;
  assign in_fire       = in_valid && (!in_item.last_char || out_free);
  assign s_axis_tready = !in_valid || in_fire;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      syntax_mode <= dtsv_pkg::MODE_MONTH;
    end else if (cfg_wr_en) begin
      syntax_mode <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.char_code <= s_axis_tdata;
      in_item.last_char <= s_axis_tlast;
    end
  end

  dtsv_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .mode   (syntax_mode),
    .step   (in_fire),
    .item   (in_item),
    .accept (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_item.last_char) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (in_fire && in_item.last_char) begin
      out_bit <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_bit};

endmodule

`default_nettype wire

### src/dtsv_parse.sv
// Per-character parse state and field checks for the date/time validator
`default_nettype none

module dtsv_parse (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [dtsv_pkg::MODE_W-1:0] mode,
  input  wire logic                      step,
  input  wire dtsv_pkg::item_t           item,
  output logic                           accept
);

  typedef enum logic [4:0] {
    PH_YEAR, PH_MON0, PH_MON1, PH_MON_END, PH_WEEK_W, PH_WEEK0, PH_WEEK1,
    PH_WEEK_END, PH_DAY0, PH_DAY1, PH_DAY_END, PH_HOUR0, PH_HOUR1, PH_HCOLON,
    PH_MIN0, PH_MIN1, PH_MIN_END, PH_SEC0, PH_SEC1, PH_SEC_END, PH_FRAC
  } phase_t;

  phase_t                        phase, phase_next, eff_phase;
  logic [2:0]                    digit_count, digit_count_next;
  logic [dtsv_pkg::YEAR_W-1:0]   year_mod, year_mod_next;
  logic [6:0]                    field, field_next;
  logic [dtsv_pkg::MONTH_W-1:0]  month, month_next;
  logic                          failed, failed_next;
  logic                          year_nz, year_nz_next;

  logic        dig;
  logic [3:0]  d;
  logic        bad;
  logic [16:0] yprod;
  logic [3:0]  yq;
  logic [5:0]  yrem;
  logic [8:0]  year_shift;
  logic [10:0] fsum;
  logic        leap;
  logic [6:0]  week_lim;
  logic [4:0]  day_lim;
  logic        mode_ok;
  logic        done_ok;

  // Character class
  assign dig = (item.char_code >= dtsv_pkg::CH_ZERO) && (item.char_code <= dtsv_pkg::CH_NINE);
  assign d   = dig ? item.char_code[3:0] : 4'd0;

  // year*10 + d modulo 400 through year mod 40 (reciprocal of 40, exact below 400)
  assign yprod      = 17'(year_mod * 8'd205);
  assign yq         = yprod[16:13];
  assign yrem       = 6'(year_mod - 9'(yq * 6'd40));
  assign year_shift = 9'(yrem * 4'd10) + 9'(d);

  // Two-digit field accumulate
  assign fsum = 11'(field * 4'd10) + 11'(d);

  // Limits from stored year and month
  assign leap     = dtsv_pkg::is_leap(year_mod);
  assign day_lim  = dtsv_pkg::days_in(month, leap);

  // Week limit is registered from the year; the year is final at least
  // three characters before the second week digit arrives
  always_ff @(posedge clk) begin
    week_lim <= dtsv_pkg::max_week(year_mod);
  end

  assign mode_ok = (mode <= dtsv_pkg::MODE_LOCAL);

  // Time-only strings start straight at the hour field
  always_comb begin
    if ((phase == PH_YEAR) && (digit_count == 3'd0) && (mode == dtsv_pkg::MODE_TIME)) begin
      eff_phase = PH_HOUR0;
    end else begin
      eff_phase = phase;
    end
  end

  // Next parse state for one character
  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    year_mod_next    = year_mod;
    field_next       = field;
    month_next       = month;
    failed_next      = failed;
    year_nz_next     = year_nz;
    bad              = 1'b0;
    if (step && !failed) begin
      if (!mode_ok) begin
        bad = 1'b1;
      end else begin
        phase_next = eff_phase;
        case (eff_phase)
          PH_YEAR: begin
            if (dig) begin
              year_mod_next = year_shift;
              if (d != 4'd0) begin
                year_nz_next = 1'b1;
              end
              if (digit_count < 3'd4) begin
                digit_count_next = digit_count + 3'd1;
              end
            end else if ((item.char_code == dtsv_pkg::CH_DASH) && (digit_count >= 3'd4)
                         && year_nz) begin
              phase_next = (mode == dtsv_pkg::MODE_WEEK) ? PH_WEEK_W : PH_MON0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_MON0, PH_WEEK0, PH_DAY0, PH_HOUR0, PH_MIN0, PH_SEC0: begin
            if (dig) begin
              field_next = 7'(d);
              phase_next = phase_t'(eff_phase + 5'd1);
            end else begin
              bad = 1'b1;
            end
          end
          PH_MON1, PH_WEEK1, PH_DAY1, PH_HOUR1, PH_MIN1, PH_SEC1: begin
            if (!dig) begin
              bad = 1'b1;
            end else begin
              field_next = fsum[6:0];
              phase_next = phase_t'(eff_phase + 5'd1);
              case (eff_phase)
                PH_MON1: begin
                  bad        = (fsum < 11'd1) || (fsum > 11'd12);
                  month_next = fsum[3:0];
                end
                PH_WEEK1: bad = (fsum < 11'd1) || (fsum > 11'(week_lim));
                PH_DAY1:  bad = (fsum < 11'd1) || (fsum > 11'(day_lim));
                PH_HOUR1: bad = (fsum > 11'd23);
                default:  bad = (fsum > 11'd59);
              endcase
            end
          end
          PH_MON_END: begin
            if ((item.char_code == dtsv_pkg::CH_DASH)
                && ((mode == dtsv_pkg::MODE_DATE) || (mode == dtsv_pkg::MODE_LOCAL))) begin
              phase_next = PH_DAY0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_WEEK_W: begin
            if (item.char_code == dtsv_pkg::CH_W) begin
              phase_next = PH_WEEK0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_DAY_END: begin
            if ((mode == dtsv_pkg::MODE_LOCAL) && ((item.char_code == dtsv_pkg::CH_T)
                || (item.char_code == dtsv_pkg::CH_SPACE))) begin
              phase_next = PH_HOUR0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_HCOLON: begin
            if (item.char_code == dtsv_pkg::CH_COLON) begin
              phase_next = PH_MIN0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_MIN_END: begin
            if (item.char_code == dtsv_pkg::CH_COLON) begin
              phase_next = PH_SEC0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_SEC_END: begin
            if (item.char_code == dtsv_pkg::CH_DOT) begin
              phase_next       = PH_FRAC;
              digit_count_next = 3'd0;
            end else begin
              bad = 1'b1;
            end
          end
          PH_FRAC: begin
            if (dig && (digit_count < 3'd3)) begin
              digit_count_next = digit_count + 3'd1;
            end else begin
              bad = 1'b1;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        failed_next = 1'b1;
      end
    end
  end

  // Verdict on the state left by the final character
  always_comb begin
    case (mode)
      dtsv_pkg::MODE_MONTH: done_ok = (phase_next == PH_MON_END);
      dtsv_pkg::MODE_WEEK:  done_ok = (phase_next == PH_WEEK_END);
      dtsv_pkg::MODE_DATE:  done_ok = (phase_next == PH_DAY_END);
      dtsv_pkg::MODE_TIME, dtsv_pkg::MODE_LOCAL: begin
        done_ok = (phase_next == PH_MIN_END) || (phase_next == PH_SEC_END)
                  || ((phase_next == PH_FRAC) && (digit_count_next >= 3'd1));
      end
      default: done_ok = 1'b0;
    endcase
  end

  assign accept = done_ok && !failed_next;

  // Parse state; cleared at reset and after each final character
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      phase       <= PH_YEAR;
      digit_count <= 3'd0;
      year_mod    <= '0;
      field       <= '0;
      month       <= '0;
      failed      <= 1'b0;
      year_nz     <= 1'b0;
    end else begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      year_mod    <= year_mod_next;
      field       <= field_next;
      month       <= month_next;
      failed      <= failed_next;
      year_nz     <= year_nz_next;
    end
  end

endmodule

`default_nettype wire

### src/dtsv_checker.sv
// Port-level checker for the date/time validator, bound to the top level
`default_nettype none

`include "date_time_string_validator_unit_assert.svh"

module dtsv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // A stalled result transaction holds its value
  `DTSV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Only the verdict bit is ever set
  `DTSV_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
  // An empty result register never holds back input
  `DTSV_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
  // Reset leaves no result pending
  `DTSV_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind date_time_string_validator_unit dtsv_checker u_dtsv_checker (.*);

`default_nettype wire

### verif/date_time_string_validator_unit_tb.sv
// Self-checking testbench for the streaming date/time string validator
module date_time_string_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [dtsv_pkg::MODE_W-1:0]  mode_t;
  typedef logic [dtsv_pkg::YEAR_W-1:0]  year_t;
  typedef logic [dtsv_pkg::MONTH_W-1:0] month_t;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_CHARS   = 40;
  localparam int          NUM_PHASES    = 8;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int          VERDICT_MODEL = -1;  // row has no typed verdict
  localparam int          NO_SPLIT      = 0;

  // mode codes with no syntax behind them
  localparam mode_t MODE_SPARE_LO = 3'd5;
  localparam mode_t MODE_SPARE_HI = 3'd7;

  // scanner position, in the order the fields appear
  typedef enum logic [4:0] {
    ST_YEAR, ST_MON_HI, ST_MON_LO, ST_MON_DONE, ST_WK_LETTER, ST_WK_HI, ST_WK_LO,
    ST_WK_DONE, ST_DAY_HI, ST_DAY_LO, ST_DAY_DONE, ST_HR_HI, ST_HR_LO, ST_HR_DONE,
    ST_MIN_HI, ST_MIN_LO, ST_MIN_DONE, ST_SEC_HI, ST_SEC_LO, ST_SEC_DONE, ST_FRAC
  } scan_state_t;

  // one directed string
  typedef struct {
    mode_t mode;
    string text;
    int    verdict;     // typed result, or VERDICT_MODEL
    int    split;       // chars sent before a mode rewrite
    mode_t mode_after;
  } row_t;

  localparam int NUM_ROWS = 27;
  row_t rows [NUM_ROWS] = '{
    '{dtsv_pkg::MODE_MONTH, "2024-02",     1, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "0000-01",     0, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "275760-12",   1, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "2024-13",     0, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "999-01",      0, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "\3772024-01", 0, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_MONTH, "7",           0, NO_SPLIT, dtsv_pkg::MODE_MONTH},
    '{dtsv_pkg::MODE_WEEK,  "2020-W53",    VERDICT_MODEL, NO_SPLIT, dtsv_pkg::MODE_WEEK},
    '{dtsv_pkg::MODE_WEEK,  "2021-W53",    VERDICT_MODEL, NO_SPLIT, dtsv_pkg::MODE_WEEK},
    '{dtsv_pkg::MODE_WEEK,  "2015-W53",    VERDICT_MODEL, NO_SPLIT, dtsv_pkg::MODE_WEEK},
    '{dtsv_pkg::MODE_WEEK,  "2019-W00",    0, NO_SPLIT, dtsv_pkg::MODE_WEEK},
    '{dtsv_pkg::MODE_DATE,  "2000-02-29",  1, NO_SPLIT, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_DATE,  "1900-02-29",  0, NO_SPLIT, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_DATE,  "2023-04-31",  0, NO_SPLIT, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_DATE,  "2023-12-3x",  0, NO_SPLIT, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_DATE,  "9999-12-31",  1, NO_SPLIT, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_TIME,  "23:59",         1, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_TIME,  "24:00",         0, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_TIME,  "00:00:59.999",  1, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_TIME,  "12:30:00.1234", 0, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_TIME,  "12:30:00.",     0, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_TIME,  "12:30.5",       0, NO_SPLIT, dtsv_pkg::MODE_TIME},
    '{dtsv_pkg::MODE_LOCAL, "2024-02-29T23:59:59.5", 1, NO_SPLIT, dtsv_pkg::MODE_LOCAL},
    '{dtsv_pkg::MODE_LOCAL, "2024-02-29 00:00",      1, NO_SPLIT, dtsv_pkg::MODE_LOCAL},
    '{MODE_SPARE_LO,        "2024-01",               0, NO_SPLIT, MODE_SPARE_LO},
    // mode rewritten in the middle of a string
    '{dtsv_pkg::MODE_MONTH, "2024-06-15", VERDICT_MODEL, 7, dtsv_pkg::MODE_DATE},
    '{dtsv_pkg::MODE_DATE,  "2024-05-07", VERDICT_MODEL, 7, MODE_SPARE_HI}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [dtsv_pkg::CHAR_W-1:0]   s_axis_tdata = '0;   // [7:0] char_code
  logic                          s_axis_tlast = 1'b0; // last_char
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;        // [0] string_valid, [7:1] zero
  logic                          cfg_wr_en = 1'b0;
  mode_t                         cfg_wr_data = '0;

  // scanner copy kept by the testbench
  mode_t               scan_mode = dtsv_pkg::MODE_MONTH;
  scan_state_t         scan_st = ST_YEAR;
  logic [2:0]          scan_ndig = '0;
  year_t               scan_year = '0;
  logic [6:0]          scan_field = '0;
  month_t              scan_month = '0;
  bit                  scan_failed = 1'b0;
  bit                  scan_year_nz = 1'b0;

  bit                  verdict_q[$];      // string_valid values still to come
  logic [7:0]          text[$];           // string under construction
  int unsigned         tx_max_gap = 19;
  int unsigned         rx_max_stall = 19;
  bit                  sink_hold_req = 1'b0;
  int unsigned         errors = 0;
  int unsigned         chars_sent = 0;
  int unsigned         strings_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         valid_seen = 0;
  int unsigned         cycle_count = 0;
  logic [7:0]          modes_covered = 8'b0000_0001;

  mode_t               phase_modes [NUM_PHASES] = '{
    dtsv_pkg::MODE_LOCAL, dtsv_pkg::MODE_WEEK, dtsv_pkg::MODE_DATE, MODE_SPARE_HI,
    dtsv_pkg::MODE_TIME, dtsv_pkg::MODE_MONTH, dtsv_pkg::MODE_LOCAL, dtsv_pkg::MODE_DATE
  };

  date_time_string_validator_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- calendar
  function automatic bit leap_year(input year_t y);
    return (y == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // 53 weeks when Jan 1 is a Thursday, or a Wednesday in a leap year
  function automatic int unsigned weeks_in_year(input year_t y);
    int unsigned prev;
    int unsigned dow;
    prev = (int'(y) + 399) % 400;
    dow  = (1 + 5 * (prev % 4) + 4 * (prev % 100) + 6 * prev) % 7;
    if (dow == 4 || (dow == 3 && leap_year(y))) return 53;
    return 52;
  endfunction

  function automatic int unsigned month_len(input month_t m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
      4'd2:                                       return leap_year(scan_year) ? 29 : 28;
      default:                                    return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic void clear_scan();
    scan_st      = ST_YEAR;
    scan_ndig    = '0;
    scan_year    = '0;
    scan_field   = '0;
    scan_month   = '0;
    scan_failed  = 1'b0;
    scan_year_nz = 1'b0;
  endfunction

  // advance the scanner by one character
  function automatic void scan_char(input logic [7:0] c);
    bit          dig;
    bit          bad;
    int unsigned d;
    int unsigned wide;
    dig = (c >= dtsv_pkg::CH_ZERO) && (c <= dtsv_pkg::CH_NINE);
    d   = dig ? int'(c - dtsv_pkg::CH_ZERO) : 0;
    bad = 1'b0;
    if (scan_mode > dtsv_pkg::MODE_LOCAL) begin
      scan_failed = 1'b1;
      return;
    end
    // time strings start directly with the hour
    if (scan_st == ST_YEAR && scan_ndig == 0 && scan_mode == dtsv_pkg::MODE_TIME)
      scan_st = ST_HR_HI;
    case (scan_st)
      ST_YEAR: begin
        if (dig) begin
          wide      = scan_year * 10 + d;
          scan_year = year_t'(wide % 400);
          if (d != 0) scan_year_nz = 1'b1;
          if (scan_ndig < 4) scan_ndig++;
        end else if (c == dtsv_pkg::CH_DASH && scan_ndig >= 4 && scan_year_nz) begin
          scan_st = (scan_mode == dtsv_pkg::MODE_WEEK) ? ST_WK_LETTER : ST_MON_HI;
        end else begin
          bad = 1'b1;
        end
      end
      ST_MON_HI, ST_WK_HI, ST_DAY_HI, ST_HR_HI, ST_MIN_HI, ST_SEC_HI: begin
        if (dig) begin
          scan_field = 7'(d);
          scan_st    = scan_state_t'(scan_st + 1);
        end else begin
          bad = 1'b1;
        end
      end
      ST_MON_LO, ST_WK_LO, ST_DAY_LO, ST_HR_LO, ST_MIN_LO, ST_SEC_LO: begin
        if (!dig) begin
          bad = 1'b1;
        end else begin
          scan_field = 7'(scan_field * 10 + d);
          case (scan_st)
            ST_MON_LO: begin
              bad        = scan_field < 1 || scan_field > 12;
              scan_month = scan_field[3:0];
            end
            ST_WK_LO:  bad = scan_field < 1 || scan_field > weeks_in_year(scan_year);
            ST_DAY_LO: bad = scan_field < 1 || scan_field > month_len(scan_month);
            ST_HR_LO:  bad = scan_field > 23;
            default:   bad = scan_field > 59;
          endcase
          scan_st = scan_state_t'(scan_st + 1);
        end
      end
      ST_MON_DONE: begin
        if (c == dtsv_pkg::CH_DASH
            && (scan_mode == dtsv_pkg::MODE_DATE || scan_mode == dtsv_pkg::MODE_LOCAL))
          scan_st = ST_DAY_HI;
        else
          bad = 1'b1;
      end
      ST_WK_LETTER: begin
        if (c == dtsv_pkg::CH_W) scan_st = ST_WK_HI;
        else bad = 1'b1;
      end
      ST_DAY_DONE: begin
        if (scan_mode == dtsv_pkg::MODE_LOCAL
            && (c == dtsv_pkg::CH_T || c == dtsv_pkg::CH_SPACE)) scan_st = ST_HR_HI;
        else bad = 1'b1;
      end
      ST_HR_DONE: begin
        if (c == dtsv_pkg::CH_COLON) scan_st = ST_MIN_HI;
        else bad = 1'b1;
      end
      ST_MIN_DONE: begin
        if (c == dtsv_pkg::CH_COLON) scan_st = ST_SEC_HI;
        else bad = 1'b1;
      end
      ST_SEC_DONE: begin
        if (c == dtsv_pkg::CH_DOT) begin
          scan_st   = ST_FRAC;
          scan_ndig = '0;
        end else begin
          bad = 1'b1;
        end
      end
      ST_FRAC: begin
        if (dig && scan_ndig < 3) scan_ndig++;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) scan_failed = 1'b1;
  endfunction

  // does the text so far form a complete string of the selected syntax
  function automatic bit string_verdict();
    if (scan_failed) return 1'b0;
    case (scan_mode)
      dtsv_pkg::MODE_MONTH: return scan_st == ST_MON_DONE;
      dtsv_pkg::MODE_WEEK:  return scan_st == ST_WK_DONE;
      dtsv_pkg::MODE_DATE:  return scan_st == ST_DAY_DONE;
      dtsv_pkg::MODE_TIME, dtsv_pkg::MODE_LOCAL:
        return scan_st == ST_MIN_DONE || scan_st == ST_SEC_DONE ||
               (scan_st == ST_FRAC && scan_ndig >= 1);
      default:    return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- string builder
  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                       input int unsigned wlo, input int unsigned whi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(wlo, whi);
    return $urandom_range(lo, hi);
  endfunction

  function automatic void push_digits(input int unsigned v, input int unsigned width);
    int unsigned div;
    div = 1;
    for (int k = 1; k < width; k++) div *= 10;
    repeat (width) begin
      text.push_back(dtsv_pkg::CH_ZERO + 8'((v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic void push_year();
    int unsigned w;
    case ($urandom_range(0, 19))
      0: push_digits(0, 4);
      1: push_digits($urandom_range(0, 999), 3);
      2: begin
        w = $urandom_range(5, 6);
        push_digits($urandom_range(1, (w == 5) ? 99999 : 999999), w);
      end
      // century and leap boundaries
      3: begin
        case ($urandom_range(0, 5))
          0: push_digits(1600, 4);
          1: push_digits(1900, 4);
          2: push_digits(2000, 4);
          3: push_digits(2004, 4);
          4: push_digits(2100, 4);
          default: push_digits(2400, 4);
        endcase
      end
      default: push_digits($urandom_range(1, 9999), 4);
    endcase
    text.push_back(dtsv_pkg::CH_DASH);
  endfunction

  function automatic void push_date();
    push_year();
    push_digits(pick(1, 12, 0, 19), 2);
    text.push_back(dtsv_pkg::CH_DASH);
    push_digits(pick(1, 31, 0, 39), 2);
  endfunction

  function automatic void push_time();
    int unsigned form;
    push_digits(pick(0, 23, 0, 29), 2);
    text.push_back(dtsv_pkg::CH_COLON);
    push_digits(pick(0, 59, 0, 69), 2);
    form = $urandom_range(0, 2);
    if (form >= 1) begin
      text.push_back(dtsv_pkg::CH_COLON);
      push_digits(pick(0, 59, 0, 69), 2);
    end
    if (form == 2) begin
      text.push_back(dtsv_pkg::CH_DOT);
      repeat (pick(1, 3, 0, 4)) text.push_back(dtsv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // mostly well-formed strings with random content, some noise and damage
  function automatic void make_string(input mode_t m);
    int unsigned r;
    text.delete();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 22 || m > dtsv_pkg::MODE_LOCAL) m = mode_t'($urandom_range(0, 4));
    case (m)
      dtsv_pkg::MODE_MONTH: begin
        push_year();
        push_digits(pick(1, 12, 0, 19), 2);
      end
      dtsv_pkg::MODE_WEEK: begin
        push_year();
        text.push_back(dtsv_pkg::CH_W);
        push_digits(pick(1, 53, 0, 59), 2);
      end
      dtsv_pkg::MODE_DATE: push_date();
      dtsv_pkg::MODE_TIME: push_time();
      default: begin
        push_date();
        r = $urandom_range(0, 19);
        if (r == 0) text.push_back(8'($urandom_range(0, 255)));
        else if (r <= 10) text.push_back(dtsv_pkg::CH_T);
        else text.push_back(dtsv_pkg::CH_SPACE);
        push_time();
      end
    endcase
    // occasional damage: a stray byte, a cut, or one digit too many
    r = $urandom_range(0, 19);
    if (r < 4) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    else if (r == 4 && text.size() > 1) void'(text.pop_back());
    else if (r == 5) text.push_back(dtsv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // ---------------------------------------------------------------- drivers
  // offer one character; predict once the transaction is accepted
  task automatic send_char(input logic [7:0] c, input bit last, input int forced);
    int unsigned gap;
    bit          verdict;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
    if (!scan_failed) scan_char(c);
    if (last) begin
      verdict = string_verdict();
      verdict_q.push_back((forced == VERDICT_MODEL) ? verdict : forced[0]);
      clear_scan();
      strings_sent++;
    end
  endtask

  // stop offering and let every pending result drain
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scan_mode = m;
    modes_covered[m] = 1'b1;
  endtask

  // ---------------------------------------------------------------- result sink
  initial begin : sink
    int unsigned stall;
    wait (!rst);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, rx_max_stall);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check
    logic [7:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transaction, tdata %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = {7'b0, verdict_q.pop_front()};
        if (want[0]) valid_seen++;
        if (m_axis_tdata !== want) begin
          $display("%0t: string_valid mismatch, expected %h, got %h",
                   $time, want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int len;
    int phase_chars;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table; the first row runs on the mode left by reset
    foreach (rows[r]) begin
      if (rows[r].mode != scan_mode) begin
        quiesce();
        write_mode(rows[r].mode);
      end
      len = rows[r].text.len();
      for (int i = 0; i < len; i++) begin
        send_char(rows[r].text[i], i == len - 1, rows[r].verdict);
        if (rows[r].split == i + 1) begin
          quiesce();
          write_mode(rows[r].mode_after);
        end
      end
    end

    // random phases, each under a mode from phase_modes and a chosen idling profile
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      write_mode(phase_modes[p]);
      tx_max_gap   = (p % 3 == 1) ? 0 : 19;
      rx_max_stall = (p == 2 || p == 4) ? 0 : 19;
      // back-pressure: sink holds off while characters keep coming
      if (p == 1) sink_hold_req = 1'b1;
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        make_string(scan_mode);
        foreach (text[i]) send_char(text[i], i == text.size() - 1, VERDICT_MODEL);
        phase_chars += text.size();
      end
    end

    quiesce();
    $display("Checked %0d strings (%0d characters), %0d results, %0d of them valid",
             strings_sent, chars_sent, results_seen, valid_seen);
    $display("Modes exercised (bit per code): %b", modes_covered);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
